// ===== hdl/hdh_pkg.sv =====
// Shared types, constants and helpers of the hue diversity histogram unit.
`default_nettype none
package hdh_pkg;

  // Counter geometry
  localparam int unsigned COUNT_BITS = 23;
  localparam int unsigned NUM_BINS   = 8;
  localparam int unsigned BIN_W      = $clog2(NUM_BINS);
  localparam int unsigned POP_W      = $clog2(NUM_BINS + 1);
  localparam int unsigned KEPT_OUT_W = 23;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Register widths and the scaled share product
  localparam int unsigned CH_W    = 8;
  localparam int unsigned SHARE_W = 7;
  localparam int unsigned MINP_W  = 4;
  localparam int unsigned PROD_W  = COUNT_BITS + SHARE_W;
  localparam int unsigned PCT_SCALE = 100;

  // BT.601 luma weights, sum over 1000
  localparam int unsigned LUMA_W   = 18;
  localparam int unsigned LUMA_R   = 299;
  localparam int unsigned LUMA_G   = 587;
  localparam int unsigned LUMA_B   = 114;
  localparam int unsigned LUMA_DIV = 1000;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FLOOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_LOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_HIGH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_FLOOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE_PERCENT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POPULATED = 3'd5;

  localparam logic [CH_W-1:0]    RST_ALPHA_FLOOR   = 8'd16;
  localparam logic [CH_W-1:0]    RST_LUMA_LOW      = 8'd32;
  localparam logic [CH_W-1:0]    RST_LUMA_HIGH     = 8'd224;
  localparam logic [CH_W-1:0]    RST_CHROMA_FLOOR  = 8'd16;
  localparam logic [SHARE_W-1:0] RST_SHARE_PERCENT = 7'd5;
  localparam logic [MINP_W-1:0]  RST_MIN_POPULATED = 4'd3;

  typedef struct packed {
    logic [CH_W-1:0]    alpha_floor;
    logic [CH_W-1:0]    luma_low;
    logic [CH_W-1:0]    luma_high;
    logic [CH_W-1:0]    chroma_floor;
    logic [SHARE_W-1:0] share_percent;
    logic [MINP_W-1:0]  min_populated;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            last;
  } pixel_t;

  typedef struct packed {
    logic             keep;
    logic [BIN_W-1:0] bin;
  } class_t;

  typedef struct packed {
    logic [NUM_BINS-1:0][COUNT_BITS-1:0] counts;
    logic [COUNT_BITS-1:0]               kept;
  } snap_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/hue_diversity_histogram_unit.sv =====
// Top level of the hue diversity histogram unit.
// Takes one RGBA pixel per clock unless stalled. Each pixel that passes the
// alpha, luma window and chroma filters adds one to one of eight 45-degree
// hue bins and to a kept count (all counters saturate). The transaction
// that carries last_pixel ends the image: its result (diverse,
// populated_bins, kept_pixels) appears on the output channel after passing
// the input register, classify, counter update, snapshot, share product,
// threshold compare and result register, and the counters restart for the
// next image at once. The sustained rate is one pixel per cycle when not
// stalled, set by the counter update. The input side stalls only when the
// output is held off, four results are already waiting (snapshot, two
// evaluation stages, result register), a further last pixel sits in the
// counter stage and the input register is full. Registers are written
// through cfg_we_i / cfg_idx_i / cfg_data_i, one per cycle; write them only
// while no pixel is in flight. Indexes beyond the list are ignored.
`default_nettype none
module hue_diversity_histogram_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [hdh_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [hdh_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // pixel channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [hdh_pkg::CH_W-1:0]          red_i,
  input  logic [hdh_pkg::CH_W-1:0]          green_i,
  input  logic [hdh_pkg::CH_W-1:0]          blue_i,
  input  logic [hdh_pkg::CH_W-1:0]          alpha_i,
  input  logic                              last_pixel_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              diverse_o,
  output logic [hdh_pkg::POP_W-1:0]         populated_bins_o,
  output logic [hdh_pkg::KEPT_OUT_W-1:0]    kept_pixels_o
);
  import hdh_pkg::*;

  cfg_t   cfg_q;
  pixel_t s1_px_q;
  logic   s1_v_q, s1_ready, in_accept;
  class_t s1_class;
  logic   acc_ready;
  logic   snap_valid, snap_ready;
  snap_t  snap;

  // register file, values masked to register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha_floor   <= RST_ALPHA_FLOOR;
      cfg_q.luma_low      <= RST_LUMA_LOW;
      cfg_q.luma_high     <= RST_LUMA_HIGH;
      cfg_q.chroma_floor  <= RST_CHROMA_FLOOR;
      cfg_q.share_percent <= RST_SHARE_PERCENT;
      cfg_q.min_populated <= RST_MIN_POPULATED;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ALPHA_FLOOR:   cfg_q.alpha_floor   <= cfg_data_i;
        REG_LUMA_LOW:      cfg_q.luma_low      <= cfg_data_i;
        REG_LUMA_HIGH:     cfg_q.luma_high     <= cfg_data_i;
        REG_CHROMA_FLOOR:  cfg_q.chroma_floor  <= cfg_data_i;
        REG_SHARE_PERCENT: cfg_q.share_percent <= cfg_data_i[SHARE_W-1:0];
        REG_MIN_POPULATED: cfg_q.min_populated <= cfg_data_i[MINP_W-1:0];
        default: ;
      endcase
    end
  end

  // input register; it drains whenever the counter stage can take it
  assign s1_ready   = !s1_v_q || acc_ready;
  assign in_stall_o = !s1_ready;
  assign in_accept  = in_valid_i && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_px_q.red   <= red_i;
      s1_px_q.green <= green_i;
      s1_px_q.blue  <= blue_i;
      s1_px_q.alpha <= alpha_i;
      s1_px_q.last  <= last_pixel_i;
    end
  end

  hdh_classify u_classify (
    .px_i    (s1_px_q),
    .cfg_i   (cfg_q),
    .class_o (s1_class)
  );

  hdh_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .px_valid_i   (s1_v_q),
    .px_ready_o   (acc_ready),
    .px_class_i   (s1_class),
    .px_last_i    (s1_px_q.last),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  hdh_evaluate u_evaluate (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .snap_valid_i     (snap_valid),
    .snap_ready_o     (snap_ready),
    .snap_i           (snap),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .diverse_o        (diverse_o),
    .populated_bins_o (populated_bins_o),
    .kept_pixels_o    (kept_pixels_o)
  );

endmodule
`default_nettype wire

// ===== hdl/hdh_classify.sv =====
// Pixel filter and hue bin selection, purely combinational.
`default_nettype none
module hdh_classify (
  input  hdh_pkg::pixel_t px_i,
  input  hdh_pkg::cfg_t   cfg_i,
  output hdh_pkg::class_t class_o
);
  import hdh_pkg::*;

  localparam int unsigned NUM_W = 14;
  localparam int unsigned THR_W = 13;

  logic [LUMA_W-1:0] luma_sum, lo_lim, hi_lim;
  logic [CH_W-1:0]   mx, mn, d;
  logic              red_max, green_max;
  logic              alpha_ok, luma_ok, chroma_ok;
  logic [NUM_W-1:0]  num, d14, r4, g4, b4;
  logic [THR_W-1:0]  three_d;
  logic [BIN_W-1:0]  bin;

  // luma in [low, high] <=> low*1000 <= sum < (high+1)*1000
  assign luma_sum = LUMA_W'(px_i.red)   * LUMA_W'(LUMA_R)
                  + LUMA_W'(px_i.green) * LUMA_W'(LUMA_G)
                  + LUMA_W'(px_i.blue)  * LUMA_W'(LUMA_B);
  assign lo_lim = LUMA_W'(cfg_i.luma_low) * LUMA_W'(LUMA_DIV);
  assign hi_lim = (LUMA_W'(cfg_i.luma_high) + 1'b1) * LUMA_W'(LUMA_DIV);
  assign luma_ok = (luma_sum >= lo_lim) && (luma_sum < hi_lim);

  assign red_max   = (px_i.red >= px_i.green) && (px_i.red >= px_i.blue);
  assign green_max = !red_max && (px_i.green >= px_i.blue);

  always_comb begin
    mx = px_i.red;
    if (px_i.green > mx) mx = px_i.green;
    if (px_i.blue > mx)  mx = px_i.blue;
    mn = px_i.red;
    if (px_i.green < mn) mn = px_i.green;
    if (px_i.blue < mn)  mn = px_i.blue;
  end

  assign d         = mx - mn;
  assign alpha_ok  = px_i.alpha >= cfg_i.alpha_floor;
  assign chroma_ok = d >= cfg_i.chroma_floor;

  assign d14 = NUM_W'(d);
  assign r4  = NUM_W'(px_i.red)   << 2;
  assign g4  = NUM_W'(px_i.green) << 2;
  assign b4  = NUM_W'(px_i.blue)  << 2;

  // Hue numerator in sixtieths scaled by 4/3 per bin; never negative, so
  // modular arithmetic gives the true value.
  always_comb begin
    priority if (red_max) begin
      num = ((px_i.green >= px_i.blue) ? '0 : NUM_W'(24) * d14) + g4 - b4;
    end else if (green_max) begin
      num = NUM_W'(8) * d14 + b4 - r4;
    end else begin
      num = NUM_W'(16) * d14 + r4 - g4;
    end
  end

  // bin = min(7, num / 3d) as a count of crossed thresholds k*3d
  assign three_d = THR_W'(d) * THR_W'(3);
  always_comb begin
    bin = '0;
    for (int k = 1; k < NUM_BINS; k++) begin
      if (num >= NUM_W'(THR_W'(k) * three_d)) bin = bin + 1'b1;
    end
    if (d == '0) bin = '0;
  end

  assign class_o.keep = alpha_ok && luma_ok && chroma_ok;
  assign class_o.bin  = bin;

endmodule
`default_nettype wire

// ===== hdl/hdh_accum.sv =====
// Hue bin and kept counters, with a snapshot register for the image end.
`default_nettype none
module hdh_accum (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            px_valid_i,
  output logic            px_ready_o,
  input  hdh_pkg::class_t px_class_i,
  input  logic            px_last_i,
  output logic            snap_valid_o,
  input  logic            snap_ready_i,
  output hdh_pkg::snap_t  snap_o
);
  import hdh_pkg::*;

  logic   s2_v_q, s2_last_q, s2_ready, s2_fire;
  class_t s2_class_q;
  logic   s3_v_q, s3_ready;
  snap_t  snap_q;

  logic [NUM_BINS-1:0][COUNT_BITS-1:0] cnt_q, cnt_upd;
  logic [COUNT_BITS-1:0]               kept_q, kept_upd;

  assign s3_ready   = !s3_v_q || snap_ready_i;
  assign s2_ready   = !s2_v_q || !s2_last_q || s3_ready;
  assign s2_fire    = s2_v_q && s2_ready;
  assign px_ready_o = s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_ready) begin
      s2_v_q <= px_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && px_valid_i) begin
      s2_class_q <= px_class_i;
      s2_last_q  <= px_last_i;
    end
  end

  always_comb begin
    cnt_upd  = cnt_q;
    kept_upd = kept_q;
    if (s2_class_q.keep) begin
      cnt_upd[s2_class_q.bin] = sat_inc(cnt_q[s2_class_q.bin]);
      kept_upd                = sat_inc(kept_q);
    end
  end

  // A last pixel hands the updated totals to the snapshot and restarts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      kept_q <= '0;
    end else if (s2_fire) begin
      if (s2_last_q) begin
        cnt_q  <= '0;
        kept_q <= '0;
      end else begin
        cnt_q  <= cnt_upd;
        kept_q <= kept_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= (s2_fire && s2_last_q) || (s3_v_q && !snap_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire && s2_last_q) begin
      snap_q.counts <= cnt_upd;
      snap_q.kept   <= kept_upd;
    end
  end

  assign snap_valid_o = s3_v_q;
  assign snap_o       = snap_q;

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire && s2_last_q |=> (kept_q == '0) && (cnt_q == '0))
    else $error("counters not cleared after image end");

  a_snap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q && !snap_ready_i |=> s3_v_q && $stable(snap_q))
    else $error("pending snapshot lost or changed");

  a_last_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && s2_last_q && !s3_ready |=> s2_v_q && s2_last_q && $stable(kept_q))
    else $error("last pixel retired while snapshot slot busy");

endmodule
`default_nettype wire

// ===== hdl/hdh_evaluate.sv =====
// Share threshold compare, bin population count and result register.
`default_nettype none
module hdh_evaluate (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hdh_pkg::cfg_t               cfg_i,
  input  logic                        snap_valid_i,
  output logic                        snap_ready_o,
  input  hdh_pkg::snap_t              snap_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        diverse_o,
  output logic [hdh_pkg::POP_W-1:0]   populated_bins_o,
  output logic [hdh_pkg::KEPT_OUT_W-1:0] kept_pixels_o
);
  import hdh_pkg::*;

  // stage 4: scaled counts and share product
  logic                              s4_v_q, s4_ready;
  logic [NUM_BINS-1:0][PROD_W-1:0]   scaled_q;
  logic [PROD_W-1:0]                 prod_q;
  logic [COUNT_BITS-1:0]             s4_kept_q;
  // stage 5: populated flags
  logic                              s5_v_q, s5_ready;
  logic [NUM_BINS-1:0]               flags_q;
  logic [COUNT_BITS-1:0]             s5_kept_q;
  // result register
  logic                              out_v_q, out_ready;
  logic                              diverse_q;
  logic [POP_W-1:0]                  pop_q, pop;
  logic [COUNT_BITS+KEPT_OUT_W-1:0]  kept_ext;
  logic [KEPT_OUT_W-1:0]             kept_out_q;

  assign out_ready    = !out_v_q || !out_stall_i;
  assign s5_ready     = !s5_v_q || out_ready;
  assign s4_ready     = !s4_v_q || s5_ready;
  assign snap_ready_o = s4_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s4_ready)  s4_v_q  <= snap_valid_i;
      if (s5_ready)  s5_v_q  <= s4_v_q;
      if (out_ready) out_v_q <= s5_v_q;
    end
  end

  // count > floor(kept*share/100)  <=>  100*count > kept*share
  always_ff @(posedge clk_i) begin
    if (s4_ready && snap_valid_i) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        scaled_q[i] <= PROD_W'(snap_i.counts[i]) * PROD_W'(PCT_SCALE);
      end
      prod_q    <= PROD_W'(snap_i.kept) * PROD_W'(cfg_i.share_percent);
      s4_kept_q <= snap_i.kept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_ready && s4_v_q) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        flags_q[i] <= scaled_q[i] > prod_q;
      end
      s5_kept_q <= s4_kept_q;
    end
  end

  always_comb begin
    pop = '0;
    for (int i = 0; i < NUM_BINS; i++) begin
      pop = pop + POP_W'(flags_q[i]);
    end
  end

  assign kept_ext = {{KEPT_OUT_W{1'b0}}, s5_kept_q};

  always_ff @(posedge clk_i) begin
    if (out_ready && s5_v_q) begin
      pop_q      <= pop;
      diverse_q  <= (s5_kept_q != '0) && (pop >= cfg_i.min_populated);
      kept_out_q <= kept_ext[KEPT_OUT_W-1:0];
    end
  end

  assign out_valid_o      = out_v_q;
  assign diverse_o        = diverse_q;
  assign populated_bins_o = pop_q;
  assign kept_pixels_o    = kept_out_q;

  a_pop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> pop_q <= POP_W'(NUM_BINS))
    else $error("populated bin count out of range");

  a_s4_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q && !s5_ready |=> s4_v_q && $stable(prod_q) && $stable(s4_kept_q))
    else $error("stalled share product changed");

endmodule
`default_nettype wire
